// ----- rtl/lts_pkg.sv -----
// Shared types and constants for the log token scanner.
package lts_pkg;

   localparam int unsigned LTS_MAX_ENTRIES = 64;
   localparam int unsigned LTS_MAX_TEXT    = 65535;
   localparam int unsigned LTS_QUEUE_DEPTH = 4;

   localparam logic [6:0]  LTS_CNT_LIMIT  =
      (LTS_MAX_ENTRIES > 127) ? 7'd127 : 7'(LTS_MAX_ENTRIES);
   localparam logic [15:0] LTS_POS_LIMIT  = 16'(LTS_MAX_TEXT);
   localparam logic [16:0] LTS_MIN_WORD   = 17'd2;
   localparam logic [16:0] LTS_MIN_DIGITS = 17'd6;

   typedef enum logic [1:0] {
      KIND_LOCATION = 2'd0,
      KIND_STAMP    = 2'd1,
      KIND_SUMMARY  = 2'd2
   } lts_kind_type;

   // everything one input byte produces, handed from scanner to emitter
   typedef struct packed {
      logic         a_valid;     // run closed by this byte
      lts_kind_type a_kind;
      logic [15:0]  a_start;
      logic [15:0]  a_len;
      logic         b_valid;     // run flushed at end of string
      lts_kind_type b_kind;
      logic [15:0]  b_start;
      logic [15:0]  b_len;
      logic [63:0]  value;       // digit run value, at most one per bundle
      logic         summary;
      logic [6:0]   token_total;
      logic [6:0]   stamp_total;
   } lts_bundle_type;

   function automatic logic [15:0] sat16(input logic [16:0] v);
      return v[16] ? 16'hFFFF : v[15:0];
   endfunction

endpackage

// ----- rtl/lts_if.sv -----
// Channel interfaces for the byte input and the result output.
interface lts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       final_byte;

   modport source (output valid, output char_byte, output final_byte, input ready);
   modport sink   (input valid, input char_byte, input final_byte, output ready);
endinterface

interface lts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] start_offset;
   logic [15:0] run_length;
   logic [63:0] stamp_value;
   logic [6:0]  token_total;
   logic [6:0]  stamp_total;
   logic        last_of_run;

   modport source (output valid, output kind, output start_offset, output run_length,
                   output stamp_value, output token_total, output stamp_total,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input start_offset, input run_length,
                   input stamp_value, input token_total, input stamp_total,
                   input last_of_run, output ready);
endinterface

// ----- rtl/lts_scan.sv -----
// Front end: classifies each byte, tracks open runs and builds result bundles.
module lts_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              char_byte,
   input  logic                    final_byte,
   output logic                    push,
   output lts_pkg::lts_bundle_type bundle,
   input  logic                    queue_ready
);
   import lts_pkg::*;

   logic [15:0] position_ff, position_in;
   logic        in_word_ff, in_word_in;
   logic [15:0] word_start_ff, word_start_in;
   logic        in_number_ff, in_number_in;
   logic [15:0] number_start_ff, number_start_in;
   logic [63:0] number_acc_ff, number_acc_in;
   logic [6:0]  word_count_ff, word_count_in;
   logic [6:0]  number_count_ff, number_count_in;

   logic        loc, dig, take;
   logic [63:0] digit, acc_next;
   logic [15:0] wstart1, nstart1;
   logic [16:0] wlen_close, nlen_close, wlen_end, nlen_end, pos_end;
   logic        wclose_ok, nclose_ok, wflush_ok, nflush_ok;
   logic [6:0]  wcnt1, ncnt1, wcnt2, ncnt2;

   assign in_ready = queue_ready;
   assign take     = in_valid && queue_ready;

   always_comb begin
      loc = (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
            (char_byte >= 8'h61 && char_byte <= 8'h7A) ||
            char_byte == 8'h2D || char_byte == 8'h5F;
      dig = char_byte >= 8'h30 && char_byte <= 8'h39;
      digit = {60'd0, 4'(char_byte - 8'h30)};
      // acc * 10 + d as shift-and-add
      acc_next = dig ? (in_number_ff ? (number_acc_ff << 3) + (number_acc_ff << 1) + digit
                                     : digit)
                     : 64'd0;
      wstart1 = (loc && !in_word_ff) ? position_ff : word_start_ff;
      nstart1 = (dig && !in_number_ff) ? position_ff : number_start_ff;

      wlen_close = {1'b0, position_ff} - {1'b0, word_start_ff};
      nlen_close = {1'b0, position_ff} - {1'b0, number_start_ff};
      wclose_ok  = !loc && in_word_ff && wlen_close >= LTS_MIN_WORD &&
                   word_count_ff < LTS_CNT_LIMIT;
      nclose_ok  = !dig && in_number_ff && nlen_close >= LTS_MIN_DIGITS &&
                   number_count_ff < LTS_CNT_LIMIT;
      wcnt1 = word_count_ff + 7'(wclose_ok);
      ncnt1 = number_count_ff + 7'(nclose_ok);

      pos_end   = {1'b0, position_ff} + 17'd1;
      wlen_end  = pos_end - {1'b0, wstart1};
      nlen_end  = pos_end - {1'b0, nstart1};
      wflush_ok = final_byte && loc && wlen_end >= LTS_MIN_WORD && wcnt1 < LTS_CNT_LIMIT;
      nflush_ok = final_byte && dig && nlen_end >= LTS_MIN_DIGITS && ncnt1 < LTS_CNT_LIMIT;
      wcnt2 = wcnt1 + 7'(wflush_ok);
      ncnt2 = ncnt1 + 7'(nflush_ok);

      bundle.a_valid     = wclose_ok || nclose_ok;
      bundle.a_kind      = nclose_ok ? KIND_STAMP : KIND_LOCATION;
      bundle.a_start     = nclose_ok ? number_start_ff : word_start_ff;
      bundle.a_len       = sat16(nclose_ok ? nlen_close : wlen_close);
      bundle.b_valid     = wflush_ok || nflush_ok;
      bundle.b_kind      = nflush_ok ? KIND_STAMP : KIND_LOCATION;
      bundle.b_start     = nflush_ok ? nstart1 : wstart1;
      bundle.b_len       = sat16(nflush_ok ? nlen_end : wlen_end);
      bundle.value       = nclose_ok ? number_acc_ff : acc_next;
      bundle.summary     = final_byte;
      bundle.token_total = wcnt2;
      bundle.stamp_total = ncnt2;

      push = take && (bundle.a_valid || bundle.b_valid || final_byte);

      position_in     = position_ff;
      in_word_in      = in_word_ff;
      word_start_in   = word_start_ff;
      in_number_in    = in_number_ff;
      number_start_in = number_start_ff;
      number_acc_in   = number_acc_ff;
      word_count_in   = word_count_ff;
      number_count_in = number_count_ff;
      if (take) begin
         if (final_byte) begin
            position_in     = '0;
            in_word_in      = 1'b0;
            word_start_in   = '0;
            in_number_in    = 1'b0;
            number_start_in = '0;
            number_acc_in   = '0;
            word_count_in   = '0;
            number_count_in = '0;
         end else begin
            position_in     = (position_ff < LTS_POS_LIMIT) ? position_ff + 16'd1
                                                            : position_ff;
            in_word_in      = loc;
            word_start_in   = wstart1;
            in_number_in    = dig;
            number_start_in = nstart1;
            number_acc_in   = acc_next;
            word_count_in   = wcnt1;
            number_count_in = ncnt1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         in_word_ff      <= 1'b0;
         word_start_ff   <= '0;
         in_number_ff    <= 1'b0;
         number_start_ff <= '0;
         number_acc_ff   <= '0;
         word_count_ff   <= '0;
         number_count_ff <= '0;
      end else begin
         position_ff     <= position_in;
         in_word_ff      <= in_word_in;
         word_start_ff   <= word_start_in;
         in_number_ff    <= in_number_in;
         number_start_ff <= number_start_in;
         number_acc_ff   <= number_acc_in;
         word_count_ff   <= word_count_in;
         number_count_ff <= number_count_in;
      end
   end

endmodule

// ----- rtl/lts_fifo.sv -----
// Short bundle queue between scanner and emitter.
module lts_fifo #(
   parameter int unsigned DEPTH = lts_pkg::LTS_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lts_pkg::lts_bundle_type push_data,
   output logic                    push_ready,
   input  logic                    pop,
   output lts_pkg::lts_bundle_type pop_data,
   output logic                    pop_valid
);
   import lts_pkg::*;

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   lts_bundle_type            store_ff [DEPTH];
   logic [ADDR_W-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/lts_emit.sv -----
// Back end: expands each bundle into one to three result words.
module lts_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  lts_pkg::lts_bundle_type q_data,
   output logic                    q_pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [1:0]              kind,
   output logic [15:0]             start_offset,
   output logic [15:0]             run_length,
   output logic [63:0]             stamp_value,
   output logic [6:0]              token_total,
   output logic [6:0]              stamp_total,
   output logic                    last_of_run
);
   import lts_pkg::*;

   lts_bundle_type cur_ff, cur_in;
   logic           pend_a_ff, pend_a_in, pend_b_ff, pend_b_in, pend_s_ff, pend_s_in;
   logic           valid_ff, valid_in;
   logic [1:0]     kind_ff, kind_in;
   logic [15:0]    start_ff, start_in, len_ff, len_in;
   logic [63:0]    value_ff, value_in;
   logic [6:0]     ttot_ff, ttot_in, stot_ff, stot_in;
   logic           last_ff, last_in;
   logic           adv, pend_any, last_sel;

   always_comb begin
      adv      = !valid_ff || out_ready;
      pend_any = pend_a_ff || pend_b_ff || pend_s_ff;
      last_sel = pend_a_ff ? !(pend_b_ff || pend_s_ff)
                           : (pend_b_ff ? !pend_s_ff : 1'b1);

      valid_in  = valid_ff;
      kind_in   = kind_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      value_in  = value_ff;
      ttot_in   = ttot_ff;
      stot_in   = stot_ff;
      last_in   = last_ff;
      pend_a_in = pend_a_ff;
      pend_b_in = pend_b_ff;
      pend_s_in = pend_s_ff;
      cur_in    = cur_ff;

      if (adv) begin
         valid_in = pend_any;
         if (pend_any) begin
            last_in = last_sel;
            ttot_in = '0;
            stot_in = '0;
            value_in = '0;
            if (pend_a_ff) begin
               pend_a_in = 1'b0;
               kind_in   = cur_ff.a_kind;
               start_in  = cur_ff.a_start;
               len_in    = cur_ff.a_len;
               if (cur_ff.a_kind == KIND_STAMP) value_in = cur_ff.value;
            end else if (pend_b_ff) begin
               pend_b_in = 1'b0;
               kind_in   = cur_ff.b_kind;
               start_in  = cur_ff.b_start;
               len_in    = cur_ff.b_len;
               if (cur_ff.b_kind == KIND_STAMP) value_in = cur_ff.value;
            end else begin
               pend_s_in = 1'b0;
               kind_in   = KIND_SUMMARY;
               start_in  = '0;
               len_in    = '0;
               ttot_in   = cur_ff.token_total;
               stot_in   = cur_ff.stamp_total;
            end
         end
      end

      // refill as soon as the last pending word of the bundle goes out
      q_pop = q_valid && (!pend_any || (adv && last_sel));
      if (q_pop) begin
         cur_in    = q_data;
         pend_a_in = q_data.a_valid;
         pend_b_in = q_data.b_valid;
         pend_s_in = q_data.summary;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
         pend_s_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         pend_a_ff <= pend_a_in;
         pend_b_ff <= pend_b_in;
         pend_s_ff <= pend_s_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      kind_ff  <= kind_in;
      start_ff <= start_in;
      len_ff   <= len_in;
      value_ff <= value_in;
      ttot_ff  <= ttot_in;
      stot_ff  <= stot_in;
      last_ff  <= last_in;
   end

   assign out_valid    = valid_ff;
   assign kind         = kind_ff;
   assign start_offset = start_ff;
   assign run_length   = len_ff;
   assign stamp_value  = value_ff;
   assign token_total  = ttot_ff;
   assign stamp_total  = stot_ff;
   assign last_of_run  = last_ff;

endmodule

// ----- rtl/log_token_scanner_top.sv -----
// Log token scanner: finds location runs and long digit runs in a byte stream.
//
// req_chan carries one text byte per word (char_byte) and final_byte on the
// last byte of a string. rsp_chan returns result words: location tokens
// (kind 0), timestamps with their decimal value (kind 1), and after the final
// byte a summary (kind 2) with both counts. last_of_run marks the last word
// caused by one input byte; a byte may cause none.
// Throughput: one byte per cycle while each byte yields at most one word and
// the receiver is ready; the emitter puts out one word per cycle while the
// receiver is ready, so a final byte that yields three words sends them one
// after another. The scanner takes bytes as long as the bundle queue
// (QUEUE_DEPTH entries) has room. A byte's result words pass the queue write,
// the emitter load and the output register; a receiver stall can hold them.
// Reset clears the scan state, the queue and the output register; the block
// is ready in the cycle after reset drops. When the receiver stalls, the
// output word holds, the queue fills and req_chan.ready drops.
module log_token_scanner_top #(
   parameter int unsigned QUEUE_DEPTH = lts_pkg::LTS_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   lts_req_if.sink   req_chan,
   lts_rsp_if.source rsp_chan
);
   import lts_pkg::*;

   lts_bundle_type push_bundle, pop_bundle;
   logic           push, push_ready, pop, pop_valid;

   lts_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .char_byte   (req_chan.char_byte),
      .final_byte  (req_chan.final_byte),
      .push        (push),
      .bundle      (push_bundle),
      .queue_ready (push_ready)
   );

   lts_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_bundle),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_data   (pop_bundle),
      .pop_valid  (pop_valid)
   );

   lts_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (pop_valid),
      .q_data       (pop_bundle),
      .q_pop        (pop),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .kind         (rsp_chan.kind),
      .start_offset (rsp_chan.start_offset),
      .run_length   (rsp_chan.run_length),
      .stamp_value  (rsp_chan.stamp_value),
      .token_total  (rsp_chan.token_total),
      .stamp_total  (rsp_chan.stamp_total),
      .last_of_run  (rsp_chan.last_of_run)
   );

endmodule

// ----- test/lts_scan_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the log token scanner: predicts the result words and checks them.
module lts_scan_checker (
   input  logic clock,
   input  logic reset,
   lts_req_if   req_chan,
   lts_rsp_if   rsp_chan,
   output int   error_count,
   output int   outstanding
);
   import lts_pkg::*;

   // counts are 7 bits wide, so the keep limit can never exceed 127
   localparam int unsigned KEEP_LIMIT = (LTS_MAX_ENTRIES > 127) ? 127 : LTS_MAX_ENTRIES;

   typedef struct {
      lts_kind_type kind;
      logic [15:0]  start_offset;
      logic [15:0]  run_length;
      logic [63:0]  stamp_value;
      logic [6:0]   token_total;
      logic [6:0]   stamp_total;
      logic         last_of_run;
   } token_word_type;

   token_word_type expected_words[$];
   token_word_type byte_words[3];
   int             byte_word_count;

   logic [15:0] scan_pos;
   logic        word_open;
   logic [15:0] word_from;
   logic        digits_open;
   logic [15:0] digits_from;
   logic [63:0] digits_value;
   logic [6:0]  words_kept;
   logic [6:0]  stamps_kept;

   task automatic clear_scan();
      scan_pos     = '0;
      word_open    = 1'b0;
      word_from    = '0;
      digits_open  = 1'b0;
      digits_from  = '0;
      digits_value = '0;
      words_kept   = '0;
      stamps_kept  = '0;
   endtask

   task automatic add_word(input lts_kind_type k, input logic [15:0] from,
                           input logic [16:0] n, input logic [63:0] v);
      byte_words[byte_word_count] = '{k, from, (n > 17'd65535) ? 16'hFFFF : n[15:0],
                                      v, 7'd0, 7'd0, 1'b0};
      byte_word_count++;
   endtask

   // run_end is exclusive: the current offset when closed by a byte, one past it at flush
   task automatic close_location(input logic [16:0] run_end);
      logic [16:0] n;
      n = run_end - {1'b0, word_from};
      if (n >= 17'd2 && words_kept < KEEP_LIMIT) begin
         words_kept++;
         add_word(KIND_LOCATION, word_from, n, 64'd0);
      end
      word_open = 1'b0;
   endtask

   task automatic close_stamp(input logic [16:0] run_end);
      logic [16:0] n;
      n = run_end - {1'b0, digits_from};
      if (n >= 17'd6 && stamps_kept < KEEP_LIMIT) begin
         stamps_kept++;
         add_word(KIND_STAMP, digits_from, n, digits_value);
      end
      digits_open  = 1'b0;
      digits_value = '0;
   endtask

   task automatic predict_byte(input logic [7:0] c, input logic fin);
      logic is_loc;
      logic is_digit;
      is_loc   = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "-" || c == "_";
      is_digit = (c >= "0" && c <= "9");
      byte_word_count = 0;

      if (is_loc) begin
         if (!word_open) begin
            word_open = 1'b1;
            word_from = scan_pos;
         end
      end else if (word_open) begin
         close_location({1'b0, scan_pos});
      end

      if (is_digit) begin
         if (!digits_open) begin
            digits_open  = 1'b1;
            digits_from  = scan_pos;
            digits_value = 64'(c - 8'd48);
         end else begin
            digits_value = digits_value * 64'd10 + 64'(c - 8'd48);
         end
      end else if (digits_open) begin
         close_stamp({1'b0, scan_pos});
      end

      if (fin) begin
         if (word_open)
            close_location({1'b0, scan_pos} + 17'd1);
         if (digits_open)
            close_stamp({1'b0, scan_pos} + 17'd1);
         add_word(KIND_SUMMARY, 16'd0, 17'd0, 64'd0);
         byte_words[byte_word_count - 1].token_total = words_kept;
         byte_words[byte_word_count - 1].stamp_total = stamps_kept;
         clear_scan();
      end else if (scan_pos < LTS_MAX_TEXT) begin
         scan_pos++;
      end

      for (int i = 0; i < byte_word_count; i++) begin
         byte_words[i].last_of_run = (i == byte_word_count - 1);
         expected_words.push_back(byte_words[i]);
      end
   endtask

   task automatic check_word();
      token_word_type want;
      if (expected_words.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display({"unexpected word: kind %0d start %0d len %0d value %0d",
                      " totals %0d/%0d last %0d"},
                     rsp_chan.kind, rsp_chan.start_offset, rsp_chan.run_length,
                     rsp_chan.stamp_value, rsp_chan.token_total, rsp_chan.stamp_total,
                     rsp_chan.last_of_run);
      end else begin
         want = expected_words.pop_front();
         if (rsp_chan.kind !== want.kind || rsp_chan.start_offset !== want.start_offset ||
             rsp_chan.run_length !== want.run_length ||
             rsp_chan.stamp_value !== want.stamp_value ||
             rsp_chan.token_total !== want.token_total ||
             rsp_chan.stamp_total !== want.stamp_total ||
             rsp_chan.last_of_run !== want.last_of_run) begin
            error_count++;
            if (error_count <= 10) begin
               $display({"word mismatch, expected: kind %0d start %0d len %0d value %0d",
                         " totals %0d/%0d last %0d"},
                        want.kind, want.start_offset, want.run_length, want.stamp_value,
                        want.token_total, want.stamp_total, want.last_of_run);
               $display({"                    got: kind %0d start %0d len %0d value %0d",
                         " totals %0d/%0d last %0d"},
                        rsp_chan.kind, rsp_chan.start_offset, rsp_chan.run_length,
                        rsp_chan.stamp_value, rsp_chan.token_total, rsp_chan.stamp_total,
                        rsp_chan.last_of_run);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         expected_words.delete();
         error_count = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_byte(req_chan.char_byte, req_chan.final_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            check_word();
      end
      outstanding = expected_words.size();
   end

endmodule

// ----- test/log_token_scanner_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the log token scanner: stimulus, receiver stalls and verdict.
module log_token_scanner_top_tb;

   localparam int RANDOM_BYTES = 120;
   localparam int HOLD_AT      = 100;
   localparam int HOLD_CYCLES  = 400;

   typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   int         error_count;
   int         outstanding;
   int         bytes_sent = 0;
   int         burst_left = 0;
   logic [7:0] text[$];

   lts_req_if req_chan();
   lts_rsp_if rsp_chan();

   log_token_scanner_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lts_scan_checker token_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("log_token_scanner_top_tb NOT OK");
      $finish;
   end

   // receiver: changing stall modes, plus one long hold so the input side backs up
   initial begin
      rx_mode_type mode;
      int          mode_left;
      logic [15:0] stall_pattern;
      bit          held;
      mode          = RX_OPEN;
      mode_left     = 0;
      stall_pattern = 16'hA5C3;
      held          = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && bytes_sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode          = rx_mode_type'($urandom_range(0, 2));
            mode_left     = $urandom_range(8, 64);
            stall_pattern = 16'($urandom);
         end
         mode_left--;
         case (mode)
            RX_OPEN:   rsp_chan.ready <= 1'b1;
            RX_RANDOM: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_chan.ready <= stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
         endcase
      end
   end

   function automatic logic [7:0] pick_location();
      int r;
      r = $urandom_range(0, 53);
      if (r < 26)
         return 8'("A" + r);
      else if (r < 52)
         return 8'("a" + r - 26);
      else if (r == 52)
         return "-";
      else
         return "_";
   endfunction

   function automatic logic [7:0] pick_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   // neither a location byte nor a digit; hugs the class boundaries
   function automatic logic [7:0] pick_other();
      int c;
      case ($urandom_range(0, 5))
         0: c = $urandom_range(128, 255);
         1: c = $urandom_range(0, 44);
         2: c = $urandom_range(46, 47);
         3: c = $urandom_range(58, 64);
         4: begin
            c = $urandom_range(91, 95);
            if (c == 95)
               c = 96;
         end
         default: c = $urandom_range(123, 127);
      endcase
      return 8'(c);
   endfunction

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
   endtask

   task automatic send_byte(input logic [7:0] c, input logic last);
      @(negedge clock);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.char_byte  <= c;
      req_chan.final_byte <= last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++)
         send_byte(text[i], i == text.size() - 1);
      text.delete();
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // mostly well-formed runs of each class, now and then plain noise
   task automatic build_random_text();
      int n;
      text.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 20)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: repeat ($urandom_range(1, 6)) text.push_back(pick_location());
               4, 5, 6: begin
                  case ($urandom_range(0, 2))
                     0: n = $urandom_range(1, 5);
                     1: n = $urandom_range(6, 9);
                     default: n = $urandom_range(10, 24);
                  endcase
                  repeat (n) text.push_back(pick_digit());
               end
               default: repeat ($urandom_range(1, 3)) text.push_back(pick_other());
            endcase
         end
      end
   endtask

   initial begin
      int random_from;
      req_chan.valid      = 1'b0;
      req_chan.char_byte  = 8'h00;
      req_chan.final_byte = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // both kinds closed by a byte, class boundaries, byte extremes, lone final letter
      push_str("AZaz-_");
      text.push_back(8'h00);
      push_str("0123456789");
      text.push_back(8'hFF);
      push_str("/:@[`{");
      text.push_back(8'h80);
      push_str("x");
      send_text();
      push_str("99999999999999999999");   // wraps past 2^64, flushed at end
      send_text();
      push_str("ab12345");
      send_text();
      push_str("123456 ");
      send_text();
      push_str("Zz");
      send_text();

      // more runs than the keep limit allows; the long receiver hold lands in here
      repeat (66) push_str("ab123456");
      push_str(".");
      send_text();
      drain_results();

      random_from = bytes_sent;
      while (bytes_sent - random_from < RANDOM_BYTES) begin
         build_random_text();
         send_text();
         if ($urandom_range(0, 3) == 0)
            drain_results();
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("log_token_scanner_top_tb OK");
      else
         $display("log_token_scanner_top_tb NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lts_pkg.sv
rtl/lts_if.sv
rtl/lts_scan.sv
rtl/lts_fifo.sv
rtl/lts_emit.sv
rtl/log_token_scanner_top.sv
test/lts_scan_checker.sv
test/log_token_scanner_top_tb.sv
